@@ design/tmc_pkg.sv @@
// Shared types and constants for the 4x4 transform matrix composer.
// Used by tmc_ctrl, tmc_dpath and transform_matrix_composer; depends on nothing.
package tmc_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int FRAC_BITS   = 16;
	localparam int CMD_WIDTH   = 3;

	typedef enum logic [CMD_WIDTH-1:0] {
		CMD_IDENTITY  = 3'd0,
		CMD_LOAD_ROW  = 3'd1,
		CMD_MULTIPLY  = 3'd2,
		CMD_TRANSLATE = 3'd3,
		CMD_SCALE     = 3'd4,
		CMD_READ      = 3'd5
	} cmd_code_t;

	// Right-hand matrix of a compose
	typedef enum logic [1:0] {
		SRC_OPERAND,
		SRC_TRANSLATE,
		SRC_SCALE
	} src_t;

	typedef struct packed {
		logic [CMD_WIDTH-1:0]          command;
		logic [1:0]                    row_index;
		logic signed [VALUE_WIDTH-1:0] value_a;
		logic signed [VALUE_WIDTH-1:0] value_b;
		logic signed [VALUE_WIDTH-1:0] value_c;
		logic signed [VALUE_WIDTH-1:0] value_d;
	} cmd_item_t;

	typedef struct packed {
		logic [1:0]                    out_row;
		logic signed [VALUE_WIDTH-1:0] out_col0;
		logic signed [VALUE_WIDTH-1:0] out_col1;
		logic signed [VALUE_WIDTH-1:0] out_col2;
		logic signed [VALUE_WIDTH-1:0] out_col3;
		logic                          last_row;
	} row_item_t;

	// Controller to datapath
	typedef struct packed {
		logic       set_identity;
		logic       load_row;
		logic       latch_xyz;
		src_t       src;
		logic       issue;
		logic [1:0] issue_row;
		logic [1:0] issue_col;
		logic       out_load;
		logic [1:0] out_row;
	} ctrl_cmd_t;

endpackage

@@ design/transform_matrix_composer.sv @@
// Top level of the 4x4 transform matrix composer.
// Instantiates tmc_ctrl and tmc_dpath; depends on tmc_pkg.

// Keeps a current 4x4 matrix (reset to identity) and a 4x4 operand matrix in
// signed fixed point with FRAC_BITS fraction bits, and composes
// current = current x M for multiply (M = operand), translate and scale.
// Identity and load-row items complete on acceptance. A compose runs the
// accept cycle, an issue phase in which four multipliers produce the 16
// result elements one at a time, and a drain of the product and sum stages;
// the input stalls meanwhile. A read streams four rows through the output
// register, one a cycle when the output is not stalled, with last_row set
// on row 3; the next item can be accepted while row 3 is still waiting.
// Products keep bits FRAC_BITS and up, dot products saturate. Operand rows
// must be loaded before a multiply uses them.
module transform_matrix_composer #(
	parameter int FRAC_BITS = tmc_pkg::FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  tmc_pkg::cmd_item_t cmd,
	output logic               row_valid,
	input  logic               row_stall,
	output tmc_pkg::row_item_t row
);

	tmc_pkg::ctrl_cmd_t ctl;

	tmc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.command   (cmd.command),
		.cmd_stall (cmd_stall),
		.row_valid (row_valid),
		.row_stall (row_stall),
		.ctl       (ctl)
	);

	tmc_dpath #(
		.FRAC_BITS (FRAC_BITS)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.cmd    (cmd),
		.row    (row)
	);

`ifndef SYNTHESIS
	// a compose command blocks the input on the following cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall && ((cmd.command == tmc_pkg::CMD_MULTIPLY) ||
		(cmd.command == tmc_pkg::CMD_TRANSLATE) || (cmd.command == tmc_pkg::CMD_SCALE))
		|=> cmd_stall)
		else $error("compose accepted without stalling the input");

	// readout rows follow each other without a gap
	assert property (@(posedge clk) disable iff (!arst_n)
		row_valid && !row_stall && !row.last_row |=> row_valid)
		else $error("gap inside a matrix readout");

	assert property (@(posedge clk) disable iff (!arst_n)
		row_valid && !row_stall && !row.last_row |=>
		row.out_row == $past(row.out_row) + 2'd1)
		else $error("readout rows out of order");
`endif

endmodule

@@ design/tmc_ctrl.sv @@
// Command sequencer of the transform matrix composer: decodes items, steps
// compose and readout. Depends on tmc_pkg.
module tmc_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	input  logic [tmc_pkg::CMD_WIDTH-1:0] command,
	output logic                         cmd_stall,
	output logic                         row_valid,
	input  logic                         row_stall,
	output tmc_pkg::ctrl_cmd_t           ctl
);

	// last count of a compose: issue while cnt_q[4] is clear, then drain the product and sum stages
	localparam logic [4:0] LAST_CNT = 5'd17;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COMPOSE,
		ST_READ
	} state_t;

	state_t          state_q;
	logic [4:0]      cnt_q;
	tmc_pkg::src_t   src_q;
	logic [1:0]      rd_row_q;
	logic            out_valid_q;
	logic            accept;
	logic            out_free;

	assign cmd_stall = (state_q != ST_IDLE);
	assign accept    = cmd_valid && (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || !row_stall;
	assign row_valid = out_valid_q;

	always_comb begin
		ctl              = '0;
		ctl.set_identity = accept && (command == tmc_pkg::CMD_IDENTITY);
		ctl.load_row     = accept && (command == tmc_pkg::CMD_LOAD_ROW);
		ctl.latch_xyz    = accept && ((command == tmc_pkg::CMD_TRANSLATE) ||
			(command == tmc_pkg::CMD_SCALE));
		ctl.src          = src_q;
		ctl.issue        = (state_q == ST_COMPOSE) && !cnt_q[4];
		ctl.issue_row    = cnt_q[3:2];
		ctl.issue_col    = cnt_q[1:0];
		ctl.out_load     = (state_q == ST_READ) && out_free;
		ctl.out_row      = rd_row_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			src_q       <= tmc_pkg::SRC_OPERAND;
			rd_row_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// refill the output register as soon as it frees up
			if ((state_q == ST_READ) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !row_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						unique case (command)
							tmc_pkg::CMD_MULTIPLY: begin
								src_q   <= tmc_pkg::SRC_OPERAND;
								cnt_q   <= '0;
								state_q <= ST_COMPOSE;
							end
							tmc_pkg::CMD_TRANSLATE: begin
								src_q   <= tmc_pkg::SRC_TRANSLATE;
								cnt_q   <= '0;
								state_q <= ST_COMPOSE;
							end
							tmc_pkg::CMD_SCALE: begin
								src_q   <= tmc_pkg::SRC_SCALE;
								cnt_q   <= '0;
								state_q <= ST_COMPOSE;
							end
							tmc_pkg::CMD_READ: begin
								rd_row_q <= '0;
								state_q  <= ST_READ;
							end
							default: begin
							end
						endcase
					end
				end
				ST_COMPOSE: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == LAST_CNT) begin
						state_q <= ST_IDLE;
					end
				end
				ST_READ: begin
					if (out_free) begin
						rd_row_q    <= rd_row_q + 2'd1;
						if (rd_row_q == 2'd3) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ design/tmc_dpath.sv @@
// Datapath of the transform matrix composer: matrix registers, four
// multipliers, adder with saturation, output register. Depends on tmc_pkg.
module tmc_dpath #(
	parameter int FRAC_BITS = tmc_pkg::FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tmc_pkg::ctrl_cmd_t   ctl,
	input  tmc_pkg::cmd_item_t   cmd,
	output tmc_pkg::row_item_t   row
);

	localparam int VW = tmc_pkg::VALUE_WIDTH;
	localparam int PW = 2 * VW;
	localparam int SW = VW + 2;
	localparam logic signed [VW-1:0] ONE_FX  = {{(VW-1){1'b0}}, 1'b1} << FRAC_BITS;
	localparam logic signed [VW-1:0] SAT_MAX = {1'b0, {(VW-1){1'b1}}};
	localparam logic signed [VW-1:0] SAT_MIN = {1'b1, {(VW-1){1'b0}}};

	logic signed [VW-1:0] cur_q    [4][4];
	logic signed [VW-1:0] op_q     [4][4];
	logic signed [VW-1:0] px_q, py_q, pz_q;
	logic signed [VW-1:0] rowbuf_q [3];

	logic signed [VW-1:0] a_in [4];
	logic signed [VW-1:0] b_in [4];
	logic signed [VW-1:0] diag_val;

	logic signed [PW-1:0] prod_s1 [4];
	logic                 valid_s1;
	logic [1:0]           row_s1, col_s1;

	logic signed [SW-1:0] acc;
	logic signed [VW-1:0] sat;
	logic signed [VW-1:0] sum_s2;
	logic                 valid_s2;
	logic [1:0]           row_s2, col_s2;

	tmc_pkg::row_item_t   out_q;

	// x, y or z for columns 0..2, 1.0 for column 3
	always_comb begin
		unique case (ctl.issue_col)
			2'd0:    diag_val = px_q;
			2'd1:    diag_val = py_q;
			2'd2:    diag_val = pz_q;
			default: diag_val = ONE_FX;
		endcase
	end

	// row of current and column of the right-hand matrix for this element
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			a_in[k] = cur_q[ctl.issue_row][k];
			unique case (ctl.src)
				tmc_pkg::SRC_TRANSLATE: begin
					if (k == 3) begin
						b_in[k] = diag_val;
					end else begin
						b_in[k] = (2'(k) == ctl.issue_col) ? ONE_FX : '0;
					end
				end
				tmc_pkg::SRC_SCALE: begin
					b_in[k] = (2'(k) == ctl.issue_col) ? diag_val : '0;
				end
				default: begin
					b_in[k] = op_q[k][ctl.issue_col];
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			prod_s1[k] <= PW'(a_in[k]) * PW'(b_in[k]);
		end
		row_s1 <= ctl.issue_row;
		col_s1 <= ctl.issue_col;
	end

	// keep product bits FRAC_BITS up, add exactly, then clamp
	always_comb begin
		acc = '0;
		for (int k = 0; k < 4; k++) begin
			acc = acc + SW'($signed(prod_s1[k][FRAC_BITS +: VW]));
		end
		if (acc > SW'(SAT_MAX)) begin
			sat = SAT_MAX;
		end else if (acc < SW'(SAT_MIN)) begin
			sat = SAT_MIN;
		end else begin
			sat = $signed(acc[VW-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		sum_s2 <= sat;
		row_s2 <= row_s1;
		col_s2 <= col_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= ctl.issue;
			valid_s2 <= valid_s1;
		end
	end

	// hold finished elements until the whole row is done, since later
	// elements of the row still read the old row
	always_ff @(posedge clk) begin
		if (valid_s2 && (col_s2 != 2'd3)) begin
			rowbuf_q[col_s2] <= sum_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 4; r++) begin
				for (int c = 0; c < 4; c++) begin
					cur_q[r][c] <= (r == c) ? ONE_FX : '0;
				end
			end
		end else if (ctl.set_identity) begin
			for (int r = 0; r < 4; r++) begin
				for (int c = 0; c < 4; c++) begin
					cur_q[r][c] <= (r == c) ? ONE_FX : '0;
				end
			end
		end else if (valid_s2 && (col_s2 == 2'd3)) begin
			for (int c = 0; c < 3; c++) begin
				cur_q[row_s2][c] <= rowbuf_q[c];
			end
			cur_q[row_s2][3] <= sum_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_row) begin
			op_q[cmd.row_index][0] <= cmd.value_a;
			op_q[cmd.row_index][1] <= cmd.value_b;
			op_q[cmd.row_index][2] <= cmd.value_c;
			op_q[cmd.row_index][3] <= cmd.value_d;
		end
		if (ctl.latch_xyz) begin
			px_q <= cmd.value_a;
			py_q <= cmd.value_b;
			pz_q <= cmd.value_c;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			out_q.out_row  <= ctl.out_row;
			out_q.out_col0 <= cur_q[ctl.out_row][0];
			out_q.out_col1 <= cur_q[ctl.out_row][1];
			out_q.out_col2 <= cur_q[ctl.out_row][2];
			out_q.out_col3 <= cur_q[ctl.out_row][3];
			out_q.last_row <= (ctl.out_row == 2'd3);
		end
	end

	assign row = out_q;

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for transform_matrix_composer: random and directed matrix commands,
// with a row predictor kept in a small class. Depends on tmc_pkg and the RTL only.

import tmc_pkg::*;

typedef logic signed [VALUE_WIDTH-1:0] fx_t;

localparam fx_t FX_ONE = fx_t'(1) <<< FRAC_BITS;
localparam fx_t FX_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
localparam fx_t FX_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

// Command codes the block must ignore
localparam logic [CMD_WIDTH-1:0] CMD_SPARE_LO = 3'd6;
localparam logic [CMD_WIDTH-1:0] CMD_SPARE_HI = 3'd7;

class transform_tracker;
	fx_t       cur [16];
	fx_t       opnd [16];
	bit [3:0]  loaded;
	row_item_t rows_due [$];
	int        mismatches;
	int        cmds_taken;
	int        composes;
	int        reads;
	int        rows_checked;

	function new();
		fill_identity(cur);
		foreach (opnd[i]) opnd[i] = '0;
		loaded = '0;
		mismatches = 0;
		cmds_taken = 0;
		composes = 0;
		reads = 0;
		rows_checked = 0;
	endfunction

	function void fill_identity(output fx_t m [16]);
		for (int i = 0; i < 16; i++)
			m[i] = (i % 5 == 0) ? FX_ONE : '0;
	endfunction

	// Full product, floor shift, keep the low word
	function fx_t fx_product(fx_t a, fx_t b);
		logic signed [2*VALUE_WIDTH-1:0] full;
		full = a * b;
		full = full >>> FRAC_BITS;
		return full[VALUE_WIDTH-1:0];
	endfunction

	function fx_t clamp(longint s);
		if (s > longint'(FX_MAX)) return FX_MAX;
		if (s < longint'(FX_MIN)) return FX_MIN;
		return s[VALUE_WIDTH-1:0];
	endfunction

	// cur = cur x rhs, row-major
	function void compose(input fx_t rhs [16]);
		fx_t    res [16];
		longint acc;
		composes++;
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				acc = 0;
				for (int k = 0; k < 4; k++)
					acc += fx_product(cur[i*4+k], rhs[k*4+j]);
				res[i*4+j] = clamp(acc);
			end
		end
		cur = res;
	endfunction

	function void absorb_cmd(cmd_item_t it);
		fx_t       rhs [16];
		row_item_t r;
		cmds_taken++;
		case (it.command)
			CMD_IDENTITY: fill_identity(cur);
			CMD_LOAD_ROW: begin
				opnd[it.row_index*4+0] = it.value_a;
				opnd[it.row_index*4+1] = it.value_b;
				opnd[it.row_index*4+2] = it.value_c;
				opnd[it.row_index*4+3] = it.value_d;
				loaded[it.row_index] = 1'b1;
			end
			CMD_MULTIPLY: compose(opnd);
			CMD_TRANSLATE: begin
				fill_identity(rhs);
				rhs[12] = it.value_a;
				rhs[13] = it.value_b;
				rhs[14] = it.value_c;
				compose(rhs);
			end
			CMD_SCALE: begin
				fill_identity(rhs);
				rhs[0]  = it.value_a;
				rhs[5]  = it.value_b;
				rhs[10] = it.value_c;
				compose(rhs);
			end
			CMD_READ: begin
				reads++;
				for (int i = 0; i < 4; i++) begin
					r.out_row  = i[1:0];
					r.out_col0 = cur[i*4+0];
					r.out_col1 = cur[i*4+1];
					r.out_col2 = cur[i*4+2];
					r.out_col3 = cur[i*4+3];
					r.last_row = (i == 3);
					rows_due.push_back(r);
				end
			end
			default: ;
		endcase
	endfunction

	function void check_row(row_item_t got);
		row_item_t want;
		rows_checked++;
		if (rows_due.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected row %0d: %h %h %h %h last %b", got.out_row,
					got.out_col0, got.out_col1, got.out_col2, got.out_col3, got.last_row);
			return;
		end
		want = rows_due.pop_front();
		if (got.out_row !== want.out_row || got.out_col0 !== want.out_col0 ||
				got.out_col1 !== want.out_col1 || got.out_col2 !== want.out_col2 ||
				got.out_col3 !== want.out_col3 || got.last_row !== want.last_row) begin
			mismatches++;
			if (mismatches <= 10)
				$display("row mismatch: expected %0d: %h %h %h %h last %b, got %0d: %h %h %h %h last %b",
					want.out_row, want.out_col0, want.out_col1, want.out_col2, want.out_col3,
					want.last_row, got.out_row, got.out_col0, got.out_col1, got.out_col2,
					got.out_col3, got.last_row);
		end
	endfunction
endclass

module testbench;

	localparam int RANDOM_ITEMS = 325;
	localparam int IDLE_LIMIT   = 2000;
	localparam int SETTLE       = 30;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_stall;
	cmd_item_t cmd       = '0;
	logic      row_valid;
	logic      row_stall = 1'b0;
	row_item_t row;

	transform_tracker tracker;
	bit               calm = 1'b0;

	transform_matrix_composer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.row_valid (row_valid),
		.row_stall (row_stall),
		.row       (row)
	);

	always #1 clk = ~clk;

	function automatic int pick_gap();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (calm || sel < 65) return 0;
		if (sel < 88) return $urandom_range(1, 3);
		if (sel < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	// Mostly small and near-unity values, some full range and edge values
	function automatic fx_t pick_value();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 45) return fx_t'($urandom_range(0, 32'h0004_0000)) - fx_t'(32'h0002_0000);
		if (sel < 60) return FX_ONE + fx_t'($urandom_range(0, 32'h2000)) - fx_t'(32'h1000);
		if (sel < 85) return fx_t'($urandom());
		case ($urandom_range(0, 5))
			0: return FX_MAX;
			1: return FX_MIN;
			2: return '0;
			3: return -1;
			4: return FX_ONE;
			default: return -FX_ONE;
		endcase
	endfunction

	function automatic cmd_item_t make_item(logic [CMD_WIDTH-1:0] op, int idx,
			fx_t a, fx_t b, fx_t c, fx_t d);
		cmd_item_t it;
		it.command   = op;
		it.row_index = idx[1:0];
		it.value_a   = a;
		it.value_b   = b;
		it.value_c   = c;
		it.value_d   = d;
		return it;
	endfunction

	function automatic cmd_item_t rand_item();
		int unsigned            sel;
		logic [CMD_WIDTH-1:0]   op;
		sel = $urandom_range(0, 99);
		if (sel < 8)       op = CMD_IDENTITY;
		else if (sel < 24) op = CMD_LOAD_ROW;
		else if (sel < 38) op = (tracker.loaded == 4'hf) ? CMD_MULTIPLY : CMD_LOAD_ROW;
		else if (sel < 52) op = CMD_TRANSLATE;
		else if (sel < 66) op = CMD_SCALE;
		else if (sel < 94) op = CMD_READ;
		else if (sel < 97) op = CMD_SPARE_LO;
		else               op = CMD_SPARE_HI;
		return make_item(op, $urandom_range(0, 3), pick_value(), pick_value(),
			pick_value(), pick_value());
	endfunction

	// Called at a falling edge; returns at the falling edge after the item is taken
	task automatic send_cmd(input cmd_item_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= it;
		do @(posedge clk); while (cmd_stall);
		tracker.absorb_cmd(it);
		@(negedge clk);
	endtask

	// Hold off the sender until every predicted row has come out
	task automatic drain_rows();
		cmd_valid <= 1'b0;
		do @(negedge clk); while (tracker.rows_due.size() != 0);
	endtask

	always @(posedge clk)
		if (arst_n && row_valid && !row_stall)
			tracker.check_row(row);

	initial begin : stall_driver
		int open;
		int hold;
		@(posedge arst_n);
		forever begin
			open = $urandom_range(1, 8);
			hold = pick_gap();
			row_stall <= 1'b0;
			repeat (open) @(negedge clk);
			if (hold > 0) begin
				row_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((cmd_valid && !cmd_stall) || (row_valid && !row_stall)) quiet = 0;
			else quiet++;
		end
		$display("no item moved for %0d cycles", IDLE_LIMIT);
		$display("Verification failed");
		$finish;
	end

	initial begin : stimulus
		cmd_item_t it;
		int        counted;
		tracker = new();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset state, ignored codes, edge-value operand rows
		send_cmd(make_item(CMD_READ, 0, 0, 0, 0, 0));
		send_cmd(make_item(CMD_SPARE_LO, 3, FX_MAX, FX_MIN, -1, FX_ONE));
		send_cmd(make_item(CMD_SPARE_HI, 1, FX_MIN, FX_MAX, FX_ONE, -1));
		send_cmd(make_item(CMD_LOAD_ROW, 0, FX_MAX, FX_MIN, 0, -1));
		send_cmd(make_item(CMD_LOAD_ROW, 1, FX_ONE, -FX_ONE, FX_MAX, FX_MIN));
		send_cmd(make_item(CMD_LOAD_ROW, 2, FX_MAX, FX_MAX, FX_MAX, FX_MAX));
		send_cmd(make_item(CMD_LOAD_ROW, 3, FX_MIN, FX_MIN, FX_MIN, FX_MIN));
		// First multiply copies the operand, the second saturates
		send_cmd(make_item(CMD_MULTIPLY, 0, 0, 0, 0, 0));
		send_cmd(make_item(CMD_READ, 3, -1, -1, -1, -1));
		send_cmd(make_item(CMD_MULTIPLY, 2, FX_MAX, FX_MAX, FX_MAX, FX_MAX));
		send_cmd(make_item(CMD_READ, 1, 0, 0, 0, 0));
		send_cmd(make_item(CMD_IDENTITY, 2, FX_MIN, FX_MIN, FX_MIN, FX_MIN));
		send_cmd(make_item(CMD_TRANSLATE, 0, 2 * FX_ONE, -FX_ONE, FX_MIN, -1));
		send_cmd(make_item(CMD_READ, 0, 0, 0, 0, 0));
		send_cmd(make_item(CMD_SCALE, 3, FX_MAX, FX_MIN, -1, FX_MIN));
		send_cmd(make_item(CMD_READ, 0, 0, 0, 0, 0));
		send_cmd(make_item(CMD_TRANSLATE, 1, FX_MAX, FX_MAX, FX_MAX, FX_MAX));
		send_cmd(make_item(CMD_READ, 2, 0, 0, 0, 0));
		for (int i = 0; i < 4; i++)
			send_cmd(make_item(CMD_LOAD_ROW, i, pick_value(), pick_value(), pick_value(),
				pick_value()));
		send_cmd(make_item(CMD_IDENTITY, 0, 0, 0, 0, 0));
		send_cmd(make_item(CMD_MULTIPLY, 0, 0, 0, 0, 0));
		send_cmd(make_item(CMD_READ, 3, 0, 0, 0, 0));
		drain_rows();

		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			if (counted % 40 == 0) calm = ($urandom_range(0, 3) == 0);
			if (counted == RANDOM_ITEMS / 2 || $urandom_range(0, 99) == 0) drain_rows();
			it = rand_item();
			send_cmd(it);
			counted++;
		end

		drain_rows();
		repeat (SETTLE) @(negedge clk);

		$display("%0d commands taken: %0d composes, %0d reads, %0d rows compared",
			tracker.cmds_taken, tracker.composes, tracker.reads, tracker.rows_checked);
		if (tracker.mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d bad or unexpected rows", tracker.mismatches);
			$display("Verification failed");
		end
		$finish;
	end

endmodule
